/* rtl/owb_pkg.sv */
// ----------------------------------------------------------------------------
// owb_pkg: shared types and constants for the 1-Wire bus master
// Item and result records, command codes and configuration register indexes.
// ----------------------------------------------------------------------------
package owb_pkg;

    localparam int CFG_W     = 12;   // width of every tick-count register
    localparam int CFG_NUM   = 8;    // number of configuration registers
    localparam int CFG_IDX_W = 3;    // index width for CFG_NUM registers

    // command codes
    localparam logic [2:0] OP_RESET = 3'd0;
    localparam logic [2:0] OP_WBYTE = 3'd1;
    localparam logic [2:0] OP_RBYTE = 3'd2;
    localparam logic [2:0] OP_WBIT  = 3'd3;
    localparam logic [2:0] OP_RBIT  = 3'd4;

    // item kinds
    localparam logic KIND_CMD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RST_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRES_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RST_REC   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_W_START   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_W_HOLD    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_R_START   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_R_WAIT    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_R_REC     = 3'd7;

    // reset values of the configuration registers
    localparam logic [CFG_W-1:0] RST_LOW_DEF   = 12'd500;
    localparam logic [CFG_W-1:0] PRES_WAIT_DEF = 12'd70;
    localparam logic [CFG_W-1:0] RST_REC_DEF   = 12'd500;
    localparam logic [CFG_W-1:0] W_START_DEF   = 12'd13;
    localparam logic [CFG_W-1:0] W_HOLD_DEF    = 12'd50;
    localparam logic [CFG_W-1:0] R_START_DEF   = 12'd5;
    localparam logic [CFG_W-1:0] R_WAIT_DEF    = 12'd5;
    localparam logic [CFG_W-1:0] R_REC_DEF     = 12'd50;

    typedef struct packed {
        logic       kind;
        logic [2:0] op;
        logic [7:0] write_data;
        logic       line_level;
    } t_item;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       device_present;
        logic [7:0] read_data;
        logic       rejected;
    } t_result;

endpackage

/* rtl/one_wire_bus_master_unit.sv */
// ----------------------------------------------------------------------------
// one_wire_bus_master_unit: 1-Wire bus master
// Reset/presence, write slots and read slots timed by an external tick.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries items: a command
//   (kind 0: reset, write byte, read byte, write bit, read bit) or a tick
//   (kind 1) carrying the sampled bus level. Ticks come from a prescaler.
//   Every item produces exactly one result transfer on the output channel
//   (o_out_valid / i_out_stall): bus drive, busy, done, presence, read data
//   and a rejected flag for commands that arrive while busy or are unknown.
//   Throughput: one item per cycle while the receiver does not stall. The
//   input transfer loads the input register; the sequencer result is pushed
//   from there into the result queue when the queue has room, and o_out_valid
//   rises once the queue holds it. The input register feeds the sequencer
//   directly; a two-entry result queue decouples the receiver. When the
//   receiver stalls, results pile up in the queue; once it is full and the
//   input register holds an item, o_in_stall goes high. Synchronous
//   active-low reset: sequencer idle, timing registers at their defaults,
//   queue empty. Timing registers are written through i_cfg_we,
//   i_cfg_index and i_cfg_wdata; the user must do so only while the unit is
//   idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module one_wire_bus_master_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_we,
    input  logic [owb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [owb_pkg::CFG_W-1:0]      i_cfg_wdata,
    // item input
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_kind,
    input  logic [2:0]                     i_op,
    input  logic [7:0]                     i_write_data,
    input  logic                           i_line_level,
    // result output
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_drive_low,
    output logic                           o_busy_res,
    output logic                           o_done_res,
    output logic                           o_device_present,
    output logic [7:0]                     o_read_data,
    output logic                           o_rejected
);

    // input register stage
    logic             r_s1_valid;
    owb_pkg::t_item   r_s1_item;
    logic             in_xfer;
    logic             go;
    logic             buf_full;
    owb_pkg::t_result core_res;
    owb_pkg::t_result out_res;

    assign o_in_stall = r_s1_valid && buf_full;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign go         = r_s1_valid && !buf_full;

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_item.kind       <= i_kind;
            r_s1_item.op         <= i_op;
            r_s1_item.write_data <= i_write_data;
            r_s1_item.line_level <= i_line_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (go) begin
            r_s1_valid <= 1'b0;
        end
    end

    // sequencer: state updates when the held item moves into the queue
    owb_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_go        (go),
        .i_item      (r_s1_item),
        .o_result    (core_res)
    );

    // result queue
    owb_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (go),
        .i_data  (core_res),
        .o_full  (buf_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (out_res)
    );

    assign o_drive_low      = out_res.drive_low;
    assign o_busy_res       = out_res.busy_res;
    assign o_done_res       = out_res.done_res;
    assign o_device_present = out_res.device_present;
    assign o_read_data      = out_res.read_data;
    assign o_rejected       = out_res.rejected;

    // an item in the input register is never dropped
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !go) |=> (r_s1_valid && $stable(r_s1_item)))
        else $error("held item lost from input register");

    // the input register is only refilled once its item has moved on
    a_s1_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && r_s1_valid) |-> go)
        else $error("input register overwritten");

    // a result flagged done never also reports rejection
    a_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && core_res.done_res) |-> !core_res.rejected)
        else $error("result both done and rejected");

endmodule

/* rtl/owb_core.sv */
// ----------------------------------------------------------------------------
// owb_core: bus sequencer
// Holds the timing registers and slot state; turns one item into one result.
// ----------------------------------------------------------------------------
module owb_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [owb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [owb_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic                           i_go,
    input  owb_pkg::t_item                 i_item,
    output owb_pkg::t_result               o_result
);

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RST_LOW  = 4'd1,
        PH_RST_WAIT = 4'd2,
        PH_RST_REC  = 4'd3,
        PH_W_START  = 4'd4,
        PH_W_HOLD   = 4'd5,
        PH_R_START  = 4'd6,
        PH_R_WAIT   = 4'd7,
        PH_R_REC    = 4'd8
    } t_phase;

    logic [owb_pkg::CFG_W-1:0] r_cfg [owb_pkg::CFG_NUM];

    t_phase                    r_phase, n_phase;
    logic [owb_pkg::CFG_W-1:0] r_tick, n_tick;
    logic [3:0]                r_bits_left, n_bits_left;
    logic [7:0]                r_shift, n_shift;
    logic [2:0]                r_cur_op, n_cur_op;
    logic                      r_presence, n_presence;
    logic [7:0]                r_last_read, n_last_read;

    logic [owb_pkg::CFG_IDX_W-1:0] lim_idx;
    logic [owb_pkg::CFG_W-1:0]     lim_raw;
    logic [owb_pkg::CFG_W-1:0]     limit;
    logic                          more;
    logic                          done;
    logic                          rejected;
    logic                          drive;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[owb_pkg::CFG_RST_LOW]   <= owb_pkg::RST_LOW_DEF;
            r_cfg[owb_pkg::CFG_PRES_WAIT] <= owb_pkg::PRES_WAIT_DEF;
            r_cfg[owb_pkg::CFG_RST_REC]   <= owb_pkg::RST_REC_DEF;
            r_cfg[owb_pkg::CFG_W_START]   <= owb_pkg::W_START_DEF;
            r_cfg[owb_pkg::CFG_W_HOLD]    <= owb_pkg::W_HOLD_DEF;
            r_cfg[owb_pkg::CFG_R_START]   <= owb_pkg::R_START_DEF;
            r_cfg[owb_pkg::CFG_R_WAIT]    <= owb_pkg::R_WAIT_DEF;
            r_cfg[owb_pkg::CFG_R_REC]     <= owb_pkg::R_REC_DEF;
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_index] <= i_cfg_wdata;
        end
    end

    // phase length select; zero counts as one
    always_comb begin
        unique case (r_phase)
            PH_RST_LOW:  lim_idx = owb_pkg::CFG_RST_LOW;
            PH_RST_WAIT: lim_idx = owb_pkg::CFG_PRES_WAIT;
            PH_RST_REC:  lim_idx = owb_pkg::CFG_RST_REC;
            PH_W_START:  lim_idx = owb_pkg::CFG_W_START;
            PH_W_HOLD:   lim_idx = owb_pkg::CFG_W_HOLD;
            PH_R_START:  lim_idx = owb_pkg::CFG_R_START;
            PH_R_WAIT:   lim_idx = owb_pkg::CFG_R_WAIT;
            default:     lim_idx = owb_pkg::CFG_R_REC;
        endcase
    end

    assign lim_raw = r_cfg[lim_idx];
    assign limit   = (lim_raw == '0) ? owb_pkg::CFG_W'(1) : lim_raw;
    assign more    = ({1'b0, r_tick} + 13'd1) < {1'b0, limit};

    always_comb begin
        n_phase     = r_phase;
        n_tick      = r_tick;
        n_bits_left = r_bits_left;
        n_shift     = r_shift;
        n_cur_op    = r_cur_op;
        n_presence  = r_presence;
        n_last_read = r_last_read;
        done        = 1'b0;
        rejected    = 1'b0;
        if (i_go) begin
            if (i_item.kind == owb_pkg::KIND_CMD) begin
                if (r_phase != PH_IDLE || i_item.op > owb_pkg::OP_RBIT) begin
                    rejected = 1'b1;
                end else begin
                    n_cur_op = i_item.op;
                    n_tick   = '0;
                    unique case (i_item.op)
                        owb_pkg::OP_RESET: begin
                            n_phase     = PH_RST_LOW;
                            n_bits_left = 4'd0;
                        end
                        owb_pkg::OP_WBYTE: begin
                            n_phase     = PH_W_START;
                            n_bits_left = 4'd8;
                            n_shift     = i_item.write_data;
                        end
                        owb_pkg::OP_WBIT: begin
                            n_phase     = PH_W_START;
                            n_bits_left = 4'd1;
                            n_shift     = {7'd0, |i_item.write_data};
                        end
                        owb_pkg::OP_RBYTE: begin
                            n_phase     = PH_R_START;
                            n_bits_left = 4'd8;
                            n_shift     = 8'd0;
                        end
                        default: begin
                            n_phase     = PH_R_START;
                            n_bits_left = 4'd1;
                            n_shift     = 8'd0;
                        end
                    endcase
                end
            end else if (r_phase != PH_IDLE) begin
                if (more) begin
                    n_tick = r_tick + owb_pkg::CFG_W'(1);
                end else begin
                    n_tick = '0;
                    unique case (r_phase)
                        PH_RST_LOW:  n_phase = PH_RST_WAIT;
                        PH_RST_WAIT: begin
                            n_presence = ~i_item.line_level;
                            n_phase    = PH_RST_REC;
                        end
                        PH_RST_REC: begin
                            n_phase = PH_IDLE;
                            done    = 1'b1;
                        end
                        PH_W_START:  n_phase = PH_W_HOLD;
                        PH_W_HOLD: begin
                            n_shift     = {1'b0, r_shift[7:1]};
                            n_bits_left = r_bits_left - 4'd1;
                            if (n_bits_left == 4'd0) begin
                                n_phase = PH_IDLE;
                                done    = 1'b1;
                            end else begin
                                n_phase = PH_W_START;
                            end
                        end
                        PH_R_START:  n_phase = PH_R_WAIT;
                        PH_R_WAIT: begin
                            n_shift = {i_item.line_level, r_shift[7:1]};
                            n_phase = PH_R_REC;
                        end
                        default: begin
                            n_bits_left = r_bits_left - 4'd1;
                            if (n_bits_left == 4'd0) begin
                                n_last_read = (r_cur_op == owb_pkg::OP_RBIT) ?
                                              {7'd0, r_shift[7]} : r_shift;
                                n_phase = PH_IDLE;
                                done    = 1'b1;
                            end else begin
                                n_phase = PH_R_START;
                            end
                        end
                    endcase
                end
            end
        end
    end

    // bus drive after this item
    always_comb begin
        unique case (n_phase)
            PH_RST_LOW, PH_W_START, PH_R_START: drive = 1'b1;
            PH_W_HOLD:                          drive = ~n_shift[0];
            default:                            drive = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_tick      <= '0;
            r_bits_left <= '0;
            r_shift     <= '0;
            r_cur_op    <= '0;
            r_presence  <= 1'b0;
            r_last_read <= '0;
        end else begin
            r_phase     <= n_phase;
            r_tick      <= n_tick;
            r_bits_left <= n_bits_left;
            r_shift     <= n_shift;
            r_cur_op    <= n_cur_op;
            r_presence  <= n_presence;
            r_last_read <= n_last_read;
        end
    end

    assign o_result.drive_low      = drive;
    assign o_result.busy_res       = (n_phase != PH_IDLE);
    assign o_result.done_res       = done;
    assign o_result.device_present = n_presence;
    assign o_result.read_data      = n_last_read;
    assign o_result.rejected       = rejected;

    // a rejected command leaves the sequencer untouched
    a_reject_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && rejected) |=> ($stable(r_phase) && $stable(r_shift) &&
                                $stable(r_bits_left) && $stable(r_tick)))
        else $error("rejected command changed sequencer state");

    // completion always lands in idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> (r_phase == PH_IDLE))
        else $error("done without returning to idle");

    // slot count never exceeds one byte
    a_bits_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bits_left <= 4'd8)
        else $error("bit counter out of range");

    // phase counter stays below its budget
    a_tick_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE && !(i_cfg_we)) |-> (r_tick < limit))
        else $error("tick counter ran past phase length");

endmodule

/* rtl/owb_out_buf.sv */
// ----------------------------------------------------------------------------
// owb_out_buf: result buffer
// Two-entry queue that holds results while the receiver stalls.
// ----------------------------------------------------------------------------
module owb_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  owb_pkg::t_result  i_data,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_stall,
    output owb_pkg::t_result  o_data
);

    owb_pkg::t_result r_data [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             pop;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign pop     = o_valid && !i_stall;
    assign o_data  = r_data[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, pop};
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd2) |-> !i_push)
        else $error("result buffer overflow");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("result buffer count out of range");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> (r_wr_ptr == r_rd_ptr))
        else $error("result buffer pointers disagree with count");

endmodule

/* verif/tb_one_wire_bus_master_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_one_wire_bus_master_unit: self-checking bench for the 1-Wire bus master
// Command and tick transfers go in with random sender gaps and receiver
// stalls. A behavioral copy of the slot sequencer predicts each item's status
// unless a directed row fixes it; results are compared with it field by field.
// ----------------------------------------------------------------------------
module tb_one_wire_bus_master_unit;

    localparam int WDOG_LIMIT  = 1000;  // cycles with no transfer on either side
    localparam int MAX_REPORTS = 10;
    localparam int PHASE_ITEMS = 80;    // live items per random timing set
    localparam int NUM_PHASES  = 8;
    localparam int DRAIN_WAIT  = 4;     // extra edges after every result is back

    localparam logic [owb_pkg::CFG_W-1:0] LEN_MIN  = 12'd1;
    localparam logic [owb_pkg::CFG_W-1:0] LEN_LONG = 12'd20;

    // op codes the block has no meaning for
    localparam logic [2:0] OP_BAD_FIRST = owb_pkg::OP_RBIT + 3'd1;
    localparam logic [2:0] OP_BAD_MID   = 3'd6;
    localparam logic [2:0] OP_BAD_LAST  = 3'd7;

    // statuses that can be read off directly
    localparam owb_pkg::t_result ST_QUIET = '{drive_low: 1'b0, busy_res: 1'b0,
        done_res: 1'b0, device_present: 1'b0, read_data: 8'h00, rejected: 1'b0};
    localparam owb_pkg::t_result ST_REJECTED = '{drive_low: 1'b0, busy_res: 1'b0,
        done_res: 1'b0, device_present: 1'b0, read_data: 8'h00, rejected: 1'b1};
    localparam owb_pkg::t_result ST_RST_LOW = '{drive_low: 1'b1, busy_res: 1'b1,
        done_res: 1'b0, device_present: 1'b0, read_data: 8'h00, rejected: 1'b0};
    localparam owb_pkg::t_result ST_RST_DONE = '{drive_low: 1'b0, busy_res: 1'b0,
        done_res: 1'b1, device_present: 1'b1, read_data: 8'h00, rejected: 1'b0};

    typedef enum logic [3:0] {
        PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_RST_REC,
        PH_W_START, PH_W_HOLD, PH_R_START, PH_R_WAIT, PH_R_REC
    } t_slot_phase;

    typedef struct packed {
        owb_pkg::t_item   it;
        logic             typed;   // 1: use exp below, 0: use the predictor
        owb_pkg::t_result exp;
    } t_dir_row;

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          cfg_we    = 1'b0;
    logic [owb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [owb_pkg::CFG_W-1:0]     cfg_wdata = '0;
    logic                          in_valid  = 1'b0;
    logic                          in_stall;
    owb_pkg::t_item                in_item   = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic                          drive_low;
    logic                          busy_res;
    logic                          done_res;
    logic                          device_present;
    logic [7:0]                    read_data;
    logic                          rejected;

    one_wire_bus_master_unit u_top (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_wdata      (cfg_wdata),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_kind           (in_item.kind),
        .i_op             (in_item.op),
        .i_write_data     (in_item.write_data),
        .i_line_level     (in_item.line_level),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_drive_low      (drive_low),
        .o_busy_res       (busy_res),
        .o_done_res       (done_res),
        .o_device_present (device_present),
        .o_read_data      (read_data),
        .o_rejected       (rejected)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Sequencer prediction: state as of the last accepted input transfer
    // ------------------------------------------------------------------------
    t_slot_phase               seq_phase;
    logic [owb_pkg::CFG_W-1:0] tick_cnt;
    logic [3:0]                bits_rem;
    logic [7:0]                shreg;
    logic [2:0]                cur_op;
    logic                      present_q;
    logic [7:0]                last_rd;
    logic [owb_pkg::CFG_W-1:0] tick_len [owb_pkg::CFG_NUM];

    owb_pkg::t_result status_q [$];   // expected status per accepted item, oldest first

    int err_cnt    = 0;
    int idle_cyc   = 0;
    int stall_left = 0;
    bit calm       = 1'b0;   // no gaps, no stalls

    // ticks a phase lasts; zero would behave as one
    function automatic logic [owb_pkg::CFG_W-1:0] phase_len(input t_slot_phase ph);
        logic [owb_pkg::CFG_W-1:0] v;
        case (ph)
            PH_RST_LOW:  v = tick_len[owb_pkg::CFG_RST_LOW];
            PH_RST_WAIT: v = tick_len[owb_pkg::CFG_PRES_WAIT];
            PH_RST_REC:  v = tick_len[owb_pkg::CFG_RST_REC];
            PH_W_START:  v = tick_len[owb_pkg::CFG_W_START];
            PH_W_HOLD:   v = tick_len[owb_pkg::CFG_W_HOLD];
            PH_R_START:  v = tick_len[owb_pkg::CFG_R_START];
            PH_R_WAIT:   v = tick_len[owb_pkg::CFG_R_WAIT];
            default:     v = tick_len[owb_pkg::CFG_R_REC];
        endcase
        return (v == '0) ? LEN_MIN : v;
    endfunction

    // advance the sequencer by one item and return the status it shows
    function automatic owb_pkg::t_result bus_step(input owb_pkg::t_item it);
        owb_pkg::t_result r;
        logic             fin;
        logic             rej;
        fin = 1'b0;
        rej = 1'b0;
        if (it.kind == owb_pkg::KIND_CMD) begin
            if (seq_phase != PH_IDLE || it.op > owb_pkg::OP_RBIT) begin
                rej = 1'b1;
            end else begin
                cur_op   = it.op;
                tick_cnt = '0;
                case (it.op)
                    owb_pkg::OP_RESET: begin
                        seq_phase = PH_RST_LOW;
                        bits_rem  = 4'd0;
                    end
                    owb_pkg::OP_WBYTE: begin
                        seq_phase = PH_W_START;
                        bits_rem  = 4'd8;
                        shreg     = it.write_data;
                    end
                    owb_pkg::OP_WBIT: begin
                        seq_phase = PH_W_START;
                        bits_rem  = 4'd1;
                        shreg     = {7'd0, it.write_data != 8'h00};
                    end
                    owb_pkg::OP_RBYTE: begin
                        seq_phase = PH_R_START;
                        bits_rem  = 4'd8;
                        shreg     = 8'h00;
                    end
                    default: begin
                        seq_phase = PH_R_START;
                        bits_rem  = 4'd1;
                        shreg     = 8'h00;
                    end
                endcase
            end
        end else if (seq_phase != PH_IDLE) begin
            if (int'(tick_cnt) + 1 < int'(phase_len(seq_phase))) begin
                tick_cnt = tick_cnt + owb_pkg::CFG_W'(1);
            end else begin
                tick_cnt = '0;
                case (seq_phase)
                    PH_RST_LOW:  seq_phase = PH_RST_WAIT;
                    PH_RST_WAIT: begin
                        present_q = ~it.line_level;   // device pulls the line low
                        seq_phase = PH_RST_REC;
                    end
                    PH_RST_REC: begin
                        seq_phase = PH_IDLE;
                        fin       = 1'b1;
                    end
                    PH_W_START:  seq_phase = PH_W_HOLD;
                    PH_W_HOLD: begin
                        shreg    = shreg >> 1;
                        bits_rem = bits_rem - 4'd1;
                        if (bits_rem == 4'd0) begin
                            seq_phase = PH_IDLE;
                            fin       = 1'b1;
                        end else begin
                            seq_phase = PH_W_START;
                        end
                    end
                    PH_R_START:  seq_phase = PH_R_WAIT;
                    PH_R_WAIT: begin
                        shreg     = {it.line_level, shreg[7:1]};   // LSB first
                        seq_phase = PH_R_REC;
                    end
                    default: begin
                        bits_rem = bits_rem - 4'd1;
                        if (bits_rem == 4'd0) begin
                            last_rd   = (cur_op == owb_pkg::OP_RBIT) ? {7'd0, shreg[7]}
                                                                     : shreg;
                            seq_phase = PH_IDLE;
                            fin       = 1'b1;
                        end else begin
                            seq_phase = PH_R_START;
                        end
                    end
                endcase
            end
        end
        case (seq_phase)
            PH_RST_LOW, PH_W_START, PH_R_START: r.drive_low = 1'b1;
            PH_W_HOLD: r.drive_low = ~shreg[0];
            default:   r.drive_low = 1'b0;
        endcase
        r.busy_res       = (seq_phase != PH_IDLE);
        r.done_res       = fin;
        r.device_present = present_q;
        r.read_data      = last_rd;
        r.rejected       = rej;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Sender side. Called at a rising edge; leaves valid high so that the
    // next item can follow back to back.
    // ------------------------------------------------------------------------
    task automatic send_item(input owb_pkg::t_item it, input logic typed,
                             input owb_pkg::t_result typed_exp);
        owb_pkg::t_result exp;
        if (!calm && $urandom_range(0, 9) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        exp = bus_step(it);
        status_q.push_back(typed ? typed_exp : exp);
    endtask

    // ticks until the current command has finished
    task automatic run_to_idle();
        owb_pkg::t_item it;
        while (seq_phase != PH_IDLE) begin
            it            = '0;
            it.kind       = owb_pkg::KIND_TICK;
            it.line_level = 1'($urandom_range(0, 1));
            send_item(it, 1'b0, ST_QUIET);
        end
    endtask

    // stop sending and wait until every transfer has come back
    task automatic settle();
        in_valid <= 1'b0;
        while (status_q.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // rewrite all timing registers; the block is idle here
    task automatic load_timing(input logic [owb_pkg::CFG_W-1:0] lens [owb_pkg::CFG_NUM]);
        settle();
        for (int i = 0; i < owb_pkg::CFG_NUM; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= owb_pkg::CFG_IDX_W'(i);
            cfg_wdata <= lens[i];
            @(posedge clk);
            tick_len[i] = lens[i];
        end
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Directed items, all phases one tick long
    // ------------------------------------------------------------------------
    t_dir_row dir_tab [25] = '{
        '{'{owb_pkg::KIND_TICK, owb_pkg::OP_RESET, 8'h00, 1'b0}, 1'b1, ST_QUIET}, // idle tick
        '{'{owb_pkg::KIND_TICK, OP_BAD_LAST, 8'hFF, 1'b1}, 1'b1, ST_QUIET},
        '{'{owb_pkg::KIND_CMD, OP_BAD_FIRST, 8'hFF, 1'b0}, 1'b1, ST_REJECTED}, // unknown op
        '{'{owb_pkg::KIND_CMD, OP_BAD_LAST, 8'h00, 1'b1}, 1'b1, ST_REJECTED},
        '{'{owb_pkg::KIND_CMD, owb_pkg::OP_RESET, 8'h00, 1'b0}, 1'b1, ST_RST_LOW},
        '{'{owb_pkg::KIND_CMD, owb_pkg::OP_RBYTE, 8'h00, 1'b0}, 1'b0, ST_QUIET}, // busy
        '{'{owb_pkg::KIND_TICK, owb_pkg::OP_RESET, 8'h00, 1'b1}, 1'b0, ST_QUIET},
        '{'{owb_pkg::KIND_TICK, owb_pkg::OP_RESET, 8'h00, 1'b0}, 1'b0, ST_QUIET}, // presence
        '{'{owb_pkg::KIND_TICK, owb_pkg::OP_RESET, 8'h00, 1'b1}, 1'b1, ST_RST_DONE},
        '{'{owb_pkg::KIND_CMD, owb_pkg::OP_WBIT, 8'h80, 1'b0}, 1'b0, ST_QUIET}, // bit 0 clear
        '{'{owb_pkg::KIND_TICK, owb_pkg::OP_RESET, 8'h00, 1'b0}, 1'b0, ST_QUIET},
        '{'{owb_pkg::KIND_TICK, owb_pkg::OP_RESET, 8'h00, 1'b0}, 1'b0, ST_QUIET},
        '{'{owb_pkg::KIND_CMD, owb_pkg::OP_WBIT, 8'h00, 1'b1}, 1'b0, ST_QUIET},
        '{'{owb_pkg::KIND_TICK, owb_pkg::OP_RESET, 8'h00, 1'b1}, 1'b0, ST_QUIET}, // held low
        '{'{owb_pkg::KIND_TICK, owb_pkg::OP_RESET, 8'h00, 1'b1}, 1'b0, ST_QUIET},
        '{'{owb_pkg::KIND_CMD, owb_pkg::OP_RBIT, 8'hFF, 1'b0}, 1'b0, ST_QUIET},
        '{'{owb_pkg::KIND_TICK, owb_pkg::OP_RESET, 8'h00, 1'b0}, 1'b0, ST_QUIET},
        '{'{owb_pkg::KIND_TICK, owb_pkg::OP_RESET, 8'h00, 1'b1}, 1'b0, ST_QUIET}, // reads a one
        '{'{owb_pkg::KIND_TICK, owb_pkg::OP_RESET, 8'h00, 1'b0}, 1'b0, ST_QUIET},
        '{'{owb_pkg::KIND_CMD, owb_pkg::OP_RESET, 8'hFF, 1'b1}, 1'b0, ST_QUIET},
        '{'{owb_pkg::KIND_TICK, owb_pkg::OP_RESET, 8'h00, 1'b0}, 1'b0, ST_QUIET},
        '{'{owb_pkg::KIND_TICK, owb_pkg::OP_RESET, 8'h00, 1'b1}, 1'b0, ST_QUIET}, // no answer
        '{'{owb_pkg::KIND_TICK, owb_pkg::OP_RESET, 8'h00, 1'b0}, 1'b0, ST_QUIET},
        '{'{owb_pkg::KIND_CMD, OP_BAD_MID, 8'h5A, 1'b0}, 1'b0, ST_QUIET},
        '{'{owb_pkg::KIND_CMD, owb_pkg::OP_WBYTE, 8'hFF, 1'b0}, 1'b0, ST_QUIET}
    };

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        owb_pkg::t_item            it;
        logic [owb_pkg::CFG_W-1:0] lens [owb_pkg::CFG_NUM];
        logic [2:0]                long_ops [3];
        int                        sent;
        int                        pick;

        tick_len  = '{owb_pkg::RST_LOW_DEF, owb_pkg::PRES_WAIT_DEF, owb_pkg::RST_REC_DEF,
                      owb_pkg::W_START_DEF, owb_pkg::W_HOLD_DEF, owb_pkg::R_START_DEF,
                      owb_pkg::R_WAIT_DEF, owb_pkg::R_REC_DEF};
        seq_phase = PH_IDLE;
        tick_cnt  = '0;
        bits_rem  = 4'd0;
        shreg     = 8'h00;
        cur_op    = owb_pkg::OP_RESET;
        present_q = 1'b0;
        last_rd   = 8'h00;
        long_ops  = '{owb_pkg::OP_RESET, owb_pkg::OP_WBIT, owb_pkg::OP_RBIT};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        lens = '{default: LEN_MIN};
        load_timing(lens);
        foreach (dir_tab[i]) send_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].exp);
        run_to_idle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            // long timing once, with only reset and bit-wide slots to keep it short
            if (p == NUM_PHASES / 2) begin
                lens = '{default: LEN_LONG};
                load_timing(lens);
                foreach (long_ops[k]) begin
                    it            = '0;
                    it.kind       = owb_pkg::KIND_CMD;
                    it.op         = long_ops[k];
                    it.write_data = 8'($urandom_range(1, 255));
                    send_item(it, 1'b0, ST_QUIET);
                    run_to_idle();
                end
            end

            // mostly short phases so that byte commands finish quickly
            foreach (lens[r]) begin
                pick    = $urandom_range(0, 9);
                lens[r] = (pick == 0) ? LEN_MIN :
                          (pick < 8)  ? owb_pkg::CFG_W'($urandom_range(2, 6)) :
                                        owb_pkg::CFG_W'($urandom_range(7, 40));
            end
            load_timing(lens);
            calm = (p == NUM_PHASES - 1);

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                it.kind       = owb_pkg::KIND_TICK;
                it.op         = 3'($urandom_range(0, 7));
                it.line_level = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 5))
                    0:       it.write_data = 8'h00;
                    1:       it.write_data = 8'hFF;
                    default: it.write_data = 8'($urandom);
                endcase
                pick = $urandom_range(0, 99);
                if (seq_phase == PH_IDLE) begin
                    if (pick < 85) begin
                        it.kind = owb_pkg::KIND_CMD;
                        it.op   = 3'($urandom_range(owb_pkg::OP_RESET, owb_pkg::OP_RBIT));
                    end else if (pick < 92) begin
                        it.kind = owb_pkg::KIND_CMD;
                        it.op   = 3'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST));
                    end
                    // else: a tick the idle sequencer ignores
                end else if (pick < 6) begin
                    it.kind = owb_pkg::KIND_CMD;   // lands mid-slot, must bounce
                end
                if (!(it.kind == owb_pkg::KIND_TICK && seq_phase == PH_IDLE))
                    sent++;
                send_item(it, 1'b0, ST_QUIET);
            end
            run_to_idle();
        end

        settle();
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver side: stall bursts and the result check
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        owb_pkg::t_result act;
        owb_pkg::t_result exp;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                act = {drive_low, busy_res, done_res, device_present, read_data, rejected};
                if (status_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("%0t: result transfer with nothing pending: %p", $time, act);
                end else begin
                    exp = status_q.pop_front();
                    if (act.drive_low !== exp.drive_low || act.busy_res !== exp.busy_res ||
                        act.done_res !== exp.done_res ||
                        act.device_present !== exp.device_present ||
                        act.read_data !== exp.read_data || act.rejected !== exp.rejected) begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS)
                            $display("%0t: status mismatch exp %p got %p", $time, exp, act);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 11);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog: any transfer on either side restarts the count
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cyc = 0;
            else
                idle_cyc++;
            if (idle_cyc >= WDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

endmodule
